>>> rtl/b2da_pkg.sv
`timescale 1ns / 1ps

package b2da_pkg;

    // Width of the binary input value
    localparam int INPUT_BITS = 32;

    // Decimal digits needed for 2**INPUT_BITS - 1 (1233/4096 ~ log10(2))
    localparam int NUM_DIGITS = ((INPUT_BITS * 1233) >> 12) + 1;
    localparam int BCD_BITS   = NUM_DIGITS * 4;

    // Shift counter must hold INPUT_BITS itself
    localparam int CNT_BITS = $clog2(INPUT_BITS + 1);

    // Digit position counter: NUM_DIGITS-1 down to 0
    localparam int POS_BITS = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    localparam int CHAR_BITS = 6;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 6'd32;

    localparam logic [POS_BITS-1:0] POS_TOP   = POS_BITS'(NUM_DIGITS - 1);
    localparam logic [1:0]          PHASE_TOP = 2'((NUM_DIGITS - 1) % 3);

    // Handoff from the converter to the character serializer
    typedef struct packed {
        logic                done;
        logic                group;
        logic [BCD_BITS-1:0] bcd;
    } dab_result_t;

endpackage

>>> rtl/b2da_dabble.sv
`timescale 1ns / 1ps

module b2da_dabble (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [b2da_pkg::INPUT_BITS-1:0] value,
    input  logic                            group_thousands,
    output logic                            busy,
    output b2da_pkg::dab_result_t           result
);
    import b2da_pkg::*;

    logic                  busy_reg, busy_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [INPUT_BITS-1:0] shift_reg, shift_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic                  group_reg, group_next;
    logic [BCD_BITS-1:0]   adjusted;
    logic                  shifting;

    // add-3 correction, per digit
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adjusted[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adjusted[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    assign shifting = busy_reg && (cnt_reg != CNT_BITS'(INPUT_BITS));

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        group_next = group_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = value;
            bcd_next   = '0;
            group_next = group_thousands;
        end
        else if (shifting)
        begin
            cnt_next   = cnt_reg + CNT_BITS'(1);
            bcd_next   = {adjusted[BCD_BITS-2:0], shift_reg[INPUT_BITS-1]};
            shift_next = shift_reg << 1;
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
        group_reg <= group_next;
    end

    assign busy         = busy_reg;
    assign result.done  = busy_reg && !shifting;
    assign result.group = group_reg;
    assign result.bcd   = bcd_reg;

endmodule

>>> rtl/b2da_emit.sv
`timescale 1ns / 1ps

module b2da_emit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  b2da_pkg::dab_result_t            result,
    output logic                             busy,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [b2da_pkg::CHAR_BITS-1:0]   character,
    output logic                             last
);
    import b2da_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  started_reg, started_next;
    logic                  space_reg, space_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [1:0]            phase_reg, phase_next;
    logic [BCD_BITS-1:0]   digits_reg, digits_next;
    logic                  group_reg, group_next;
    logic [CHAR_BITS-1:0]  char_reg, char_next;
    logic                  last_reg, last_next;

    logic                  out_free;
    logic                  emit;
    logic                  advance;
    logic [3:0]            top_digit;

    assign out_free  = !out_valid_reg || !out_stall;
    assign top_digit = digits_reg[BCD_BITS-1 -: 4];

    always_comb
    begin
        busy_next    = busy_reg;
        started_next = started_reg;
        space_next   = space_reg;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        digits_next  = digits_reg;
        group_next   = group_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        emit         = 1'b0;
        advance      = 1'b0;

        if (result.done)
        begin
            busy_next    = 1'b1;
            started_next = 1'b0;
            space_next   = 1'b0;
            pos_next     = POS_TOP;
            phase_next   = PHASE_TOP;
            digits_next  = result.bcd;
            group_next   = result.group;
        end
        else if (busy_reg && out_free)
        begin
            if (space_reg)
            begin
                emit       = 1'b1;
                char_next  = CHAR_SPACE;
                last_next  = 1'b0;
                space_next = 1'b0;
            end
            else if (!started_reg && (top_digit == 4'd0) && (pos_reg != '0))
            begin
                // leading zero: drop it
                advance = 1'b1;
            end
            else
            begin
                emit         = 1'b1;
                char_next    = CHAR_ZERO + {2'b00, top_digit};
                last_next    = (pos_reg == '0);
                started_next = 1'b1;
                space_next   = group_reg && (pos_reg != '0) && (phase_reg == 2'd0);
                if (pos_reg == '0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
        end

        if (advance)
        begin
            digits_next = digits_reg << 4;
            pos_next    = pos_reg - POS_BITS'(1);
            phase_next  = (phase_reg == 2'd0) ? 2'd2 : phase_reg - 2'd1;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            space_reg     <= 1'b0;
            pos_reg       <= '0;
            phase_reg     <= 2'd0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
            space_reg     <= space_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        group_reg  <= group_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign busy      = busy_reg;
    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

>>> rtl/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// An accepted number is first converted by the double dabble shifter, then the serializer skips
//   leading zeros before loading the first character into the output register; stalls delay it.
// One transaction at a time: the next is accepted the cycle after the last character is loaded.
// The shifter takes one input bit per cycle, the serializer one digit or space per cycle while
//   the output is not stalled. Reset (rst_n, async, active low) clears all control state;
//   nothing else persists.

module binary_to_decimal_ascii (
    input  logic                            clk,
    input  logic                            rst_n,

    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [b2da_pkg::INPUT_BITS-1:0] value,
    input  logic                            group_thousands,

    // output channel: one character per transaction
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [b2da_pkg::CHAR_BITS-1:0]  character,
    output logic                            last
);
    import b2da_pkg::*;

    logic        dab_busy;
    logic        emit_busy;
    logic        start;
    dab_result_t dab_result;

    // One number in flight: the converter and the serializer must both be idle.
    // A finished character may still sit in the output register.
    assign in_stall = dab_busy || emit_busy;
    assign start    = in_valid && !in_stall;

    // Bit-serial double dabble: one input bit per cycle into the BCD register
    b2da_dabble u_dabble (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .value           (value),
        .group_thousands (group_thousands),
        .busy            (dab_busy),
        .result          (dab_result)
    );

    // Digit-serial character generator: walks the BCD digits from the top,
    // drops leading zeros, inserts grouping spaces and marks the ones digit last
    b2da_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (dab_result),
        .busy      (emit_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

    import b2da_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset, DUT ports
    // ------------------------------------------------------------------
    logic                  clk             = 1'b0;
    logic                  rst_n           = 1'b0;

    logic                  in_valid        = 1'b0;
    logic                  in_stall;
    logic [INPUT_BITS-1:0] value           = '0;
    logic                  group_thousands = 1'b0;

    logic                  out_valid;
    logic                  out_stall       = 1'b0;
    logic [CHAR_BITS-1:0]  character;
    logic                  last;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    binary_to_decimal_ascii DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .value           (value),
        .group_thousands (group_thousands),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .character       (character),
        .last            (last)
    );

    // ------------------------------------------------------------------
    // Expected characters, oldest first. num is kept only for messages.
    // ------------------------------------------------------------------
    typedef struct {
        logic [CHAR_BITS-1:0]  ch;
        logic                  is_last;
        logic [INPUT_BITS-1:0] num;
    } char_rec_t;

    char_rec_t pending_chars [$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  tx_idle_on  = 1'b1;   // sender inserts random gaps
    bit  rx_idle_on  = 1'b1;   // receiver inserts random stalls

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 80;    // > conversion latency + max characters
    localparam int RAND_ITEMS  = 312;
    localparam int RAND_PHASES = 4;

    // Decimal text of a number: digits MSB first, no leading zeros, a space
    // after the thousands/millions/billions digit when grouping is on.
    // Only the ones digit carries the last flag.
    function automatic void format_decimal(input logic [INPUT_BITS-1:0] num,
                                           input logic grp);
        longint unsigned rem;
        int              digit [20];
        int              cnt;
        char_rec_t       rec;
        rem = num;
        cnt = 0;
        do
        begin
            digit[cnt] = int'(rem % 10);
            rem        = rem / 10;
            cnt++;
        end
        while (rem != 0);
        rec.num = num;
        for (int pos = cnt - 1; pos >= 0; pos--)
        begin
            rec.ch      = CHAR_ZERO + CHAR_BITS'(digit[pos]);
            rec.is_last = (pos == 0);
            pending_chars.push_back(rec);
            if (grp && pos > 0 && (pos % 3) == 0)
            begin
                rec.ch      = CHAR_SPACE;
                rec.is_last = 1'b0;
                pending_chars.push_back(rec);
            end
        end
    endfunction

    // Hand-written expectation: the string as typed, last flag on the final char.
    function automatic void expect_text(input string txt, input logic [INPUT_BITS-1:0] num);
        char_rec_t rec;
        rec.num = num;
        for (int i = 0; i < txt.len(); i++)
        begin
            rec.ch      = CHAR_BITS'(txt[i]);
            rec.is_last = (i == txt.len() - 1);
            pending_chars.push_back(rec);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: one input transaction per call. Called right after a rising
    // edge, so every assignment here lands at that edge. When the gap is zero
    // in_valid simply stays high with the new payload.
    // ------------------------------------------------------------------
    task automatic send_number(input logic [INPUT_BITS-1:0] num, input logic grp,
                               input string txt);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        value           <= num;
        group_thousands <= grp;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        // accepted at this edge
        if (txt.len() != 0)
            expect_text(txt, num);
        else
            format_decimal(num, grp);
    endtask

    // Random value with a spread of digit counts, so grouping positions and
    // leading-zero skips of every length get hit.
    function automatic logic [INPUT_BITS-1:0] pick_value();
        longint unsigned p;
        longint unsigned hi;
        int              d;
        p = 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                d = $urandom_range(1, 10);
                repeat (d - 1) p = p * 10;
                hi = p * 10 - 1;
                if (hi > 64'hFFFF_FFFF)
                    hi = 64'hFFFF_FFFF;
                return $urandom_range(hi[31:0], (d == 1) ? 0 : p[31:0]);
            end
            6:
                return $urandom;
            7:
            begin
                // decade boundaries: 10^k - 1, 10^k, 10^k + 1
                repeat ($urandom_range(0, 9)) p = p * 10;
                p = p + $urandom_range(0, 2) - 1;
                return p[31:0];
            end
            8:
                return $urandom_range(0, 20);
            default:
                return (32'hFFFF_FFFF - $urandom_range(0, 3)) & ($urandom | $urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Text is typed only where it is obvious; an empty
    // string means the predictor works it out.
    // ------------------------------------------------------------------
    localparam int DIR_N = 20;

    logic [INPUT_BITS-1:0] dir_value [DIR_N] = '{
        32'd0,          32'd0,          32'd1,          32'd9,
        32'd10,         32'd999,        32'd1000,       32'd999999,
        32'd1000000,    32'd1000000000, 32'hFFFF_FFFF,  32'hFFFF_FFFF,
        32'h8000_0000,  32'h5555_5555,  32'hAAAA_AAAA,  32'd12345,
        32'd100,        32'd1234567890, 32'd999999999,  32'd7000
    };

    logic dir_group [DIR_N] = '{
        1'b0, 1'b1, 1'b1, 1'b0,
        1'b1, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b1, 1'b0, 1'b1,
        1'b1, 1'b0, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b0
    };

    string dir_text [DIR_N] = '{
        "0",             "0",             "1",              "9",
        "10",            "999",           "1 000",          "999 999",
        "1000000",       "1 000 000 000", "4294967295",     "4 294 967 295",
        "",              "",              "",               "",
        "100",           "1 234 567 890", "",               "7000"
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_number(dir_value[i], dir_group[i], dir_text[i]);

        // Random phases: both idling, none, sender only, receiver only.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            tx_idle_on = (ph == 0) || (ph == 2);
            rx_idle_on = (ph == 0) || (ph == 3);
            for (int i = 0; i < RAND_ITEMS / RAND_PHASES; i++)
                send_number(pick_value(), 1'($urandom), "");
        end
        in_valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: checks each output transaction against the oldest
    // expectation, then draws how long to stall before the next one.
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin
        char_rec_t exp_c;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_chars.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected char %0d last %0d", character, last);
                end
                else
                begin
                    exp_c = pending_chars.pop_front();
                    if (character !== exp_c.ch || last !== exp_c.is_last)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("value %0d: expected char %0d last %0d, got char %0d last %0d",
                                     exp_c.num, exp_c.ch, exp_c.is_last, character, last);
                    end
                end
                stall_left = rx_idle_on ? $urandom_range(0, 10) : 0;
            end
            else if (stall_left > 0)
                stall_left--;
        end
        out_stall <= (stall_left != 0);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

endmodule
